FILE: sv/clb_pkg.sv
// Package for the circular LBP block: pixel and window types, sizes,
// register codes and the bilinear tap table. No dependencies.
`default_nettype none

package clb_pkg;

  localparam int PIX_W      = 8;
  localparam int WIN        = 3;
  localparam int LINES      = 2;
  localparam int NB         = 8;
  localparam int NTAP       = 4;
  localparam int WT_W       = 9;
  localparam int ACC_W      = PIX_W + WT_W;
  localparam int CFG_W      = 13;
  localparam int ROW_W      = 12;
  localparam int HGT_W      = 13;
  localparam int MIN_SIZE   = 3;
  localparam int MAX_HEIGHT = 4096;
  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [NB-1:0]    code_t;

  typedef struct packed {
    logic signed [1:0] dy;
    logic signed [1:0] dx;
    logic [WT_W-1:0]   w;
  } tap_t;

  // Q1.8 weights, four taps per circle sample.
  localparam tap_t TAPS [NB][NTAP] = '{
    '{'{2'sd1, 2'sd0, 9'd256}, '{2'sd0, 2'sd0, 9'd0},
      '{2'sd0, 2'sd0, 9'd0},   '{2'sd0, 2'sd0, 9'd0}},
    '{'{2'sd0, -2'sd1, 9'd53}, '{2'sd0, 2'sd0, 9'd22},
      '{2'sd1, -2'sd1, 9'd128}, '{2'sd1, 2'sd0, 9'd53}},
    '{'{2'sd0, -2'sd1, 9'd256}, '{2'sd0, 2'sd0, 9'd0},
      '{2'sd0, 2'sd0, 9'd0},   '{2'sd0, 2'sd0, 9'd0}},
    '{'{-2'sd1, -2'sd1, 9'd128}, '{-2'sd1, 2'sd0, 9'd53},
      '{2'sd0, -2'sd1, 9'd53}, '{2'sd0, 2'sd0, 9'd22}},
    '{'{-2'sd1, 2'sd0, 9'd256}, '{2'sd0, 2'sd0, 9'd0},
      '{2'sd0, 2'sd0, 9'd0},   '{2'sd0, 2'sd0, 9'd0}},
    '{'{-2'sd1, 2'sd0, 9'd53}, '{-2'sd1, 2'sd1, 9'd128},
      '{2'sd0, 2'sd0, 9'd22},  '{2'sd0, 2'sd1, 9'd53}},
    '{'{2'sd0, 2'sd1, 9'd256}, '{2'sd0, 2'sd0, 9'd0},
      '{2'sd0, 2'sd0, 9'd0},   '{2'sd0, 2'sd0, 9'd0}},
    '{'{2'sd0, 2'sd0, 9'd22},  '{2'sd0, 2'sd1, 9'd53},
      '{2'sd1, 2'sd0, 9'd53},  '{2'sd1, 2'sd1, 9'd128}}
  };

  // One new window column: two stored rows and the incoming pixel.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // Item state after the line store read.
  typedef struct packed {
    logic emit;
    logic frame_end;
    logic par;
    pix_t pixel;
  } s1_t;

endpackage

`default_nettype wire

FILE: sv/circular_lbp_bilinear.sv
// Circular LBP (radius 1, 8 samples, bilinear) over a raster pixel stream.
// One pixel per clock when the output side is ready; a code goes from its
// center's last needed pixel through the line store read at the accepting
// edge, then the window shift, then the output register. The two previous
// rows live in two synchronous RAMs of MAX_WIDTH pixels, each read once and
// one of them written once per pixel, which allows one pixel per cycle when
// the output side is ready. Border pixels give no code; tlast marks the last
// code of a frame. Width and height are clamped to [3, MAX_WIDTH] and
// [3, 4096]. Depends on clb_pkg, clb_ram and clb_code.
`default_nettype none

module circular_lbp_bilinear
  import clb_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_addr_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,   // [7:0] pixel
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [7:0]       m_axis_tdata,   // [7:0] lbp_code
  output logic                  m_axis_tlast    // frame_end
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  logic [CFG_W-1:0] width_q, height_q;
  logic [CW-1:0]    col_q, col_d, c_eff;
  logic [ROW_W-1:0] row_q, row_d, r_eff;
  logic [WW-1:0]    w_lim, c_inc;
  logic [HGT_W-1:0] h_lim, r_tmp, r_inc;
  logic             col_wrap, in_acc;

  s1_t   s1_q;
  logic  s1_v_q, s1_v_d, s1_go;
  logic  s2_v_q, s2_v_d, s2_fe_q, s2_go, out_free;
  logic  out_v_q, out_v_d, out_last_q;
  code_t out_code_q, code;
  pix_t  rd [LINES];
  col_t  col;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(width_q) < MIN_SIZE) begin
      w_lim = WW'(MIN_SIZE);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_lim = WW'(MAX_WIDTH);
    end else begin
      w_lim = WW'(width_q);
    end
    if (int'(height_q) < MIN_SIZE) begin
      h_lim = HGT_W'(MIN_SIZE);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      h_lim = HGT_W'(MAX_HEIGHT);
    end else begin
      h_lim = height_q;
    end
  end

  // Position of the incoming pixel, with wrap after a size change.
  always_comb begin
    col_wrap = ({1'b0, col_q} >= w_lim);
    c_eff    = col_wrap ? '0 : col_q;
    r_tmp    = {1'b0, row_q} + HGT_W'(col_wrap);
    r_eff    = (r_tmp >= h_lim) ? '0 : r_tmp[ROW_W-1:0];
    c_inc    = {1'b0, c_eff} + WW'(1);
    r_inc    = {1'b0, r_eff} + HGT_W'(1);
    col_d    = col_q;
    row_d    = row_q;
    if (in_acc) begin
      if (c_inc >= w_lim) begin
        col_d = '0;
        row_d = (r_inc >= h_lim) ? '0 : r_inc[ROW_W-1:0];
      end else begin
        col_d = c_inc[CW-1:0];
        row_d = r_eff;
      end
    end
  end

  // Handshake chain: output register, window stage, line store stage.
  assign out_free      = !out_v_q || m_axis_tready;
  assign s2_go         = s2_v_q && out_free;
  assign s1_go         = s1_v_q && (!s2_v_q || out_free);
  assign s_axis_tready = !s1_v_q || s1_go;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_v_d = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_v_q);
    s2_v_d = s1_go ? s1_q.emit : (s2_go ? 1'b0 : s2_v_q);
    out_v_d = s2_go ? 1'b1 : (m_axis_tready ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.emit      <= (int'(r_eff) >= LINES) && (int'(c_eff) >= LINES);
      s1_q.frame_end <= ({1'b0, r_eff} == h_lim - HGT_W'(1)) &&
                        ({1'b0, c_eff} == w_lim - WW'(1));
      s1_q.par       <= r_eff[0];
      s1_q.pixel     <= s_axis_tdata;
    end
    if (s1_go) begin
      s2_fe_q <= s1_q.frame_end;
    end
    if (s2_go) begin
      out_code_q <= code;
      out_last_q <= s2_fe_q;
    end
  end

  for (genvar g = 0; g < LINES; g++) begin : g_line
    clb_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk_i   (clk_i),
      .we_i    (in_acc && (r_eff[0] == 1'(g))),
      .waddr_i (c_eff),
      .wdata_i (s_axis_tdata),
      .re_i    (in_acc),
      .raddr_i (c_eff),
      .rdata_o (rd[g])
    );
  end

  assign col.top = s1_q.par ? rd[1] : rd[0];
  assign col.mid = s1_q.par ? rd[0] : rd[1];
  assign col.bot = s1_q.pixel;

  clb_code u_code (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_go),
    .col_i   (col),
    .code_o  (code)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_code_q;
  assign m_axis_tlast  = out_last_q;

  a_no_acc_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && s1_v_q && !s1_go))
    else $error("pixel accepted while line store stage blocked");

  a_window_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && !out_free |=> s2_v_q)
    else $error("window item lost while output stalled");

  a_s1_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && !in_acc |=> !s1_v_q)
    else $error("line store stage kept a moved item");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_go |=> m_axis_tvalid)
    else $error("code moved out of window but output not valid");

endmodule

`default_nettype wire

FILE: sv/clb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read returns the old contents on a same-address write. No dependencies.
`default_nettype none

module clb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/clb_code.sv
// 3x3 window registers and the bilinear LBP code logic.
// Depends on clb_pkg for the tap table and the column type.
`default_nettype none

module clb_code
  import clb_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  shift_i,
  input  wire col_t  col_i,
  output code_t      code_o
);

  pix_t win_q [WIN][WIN];
  pix_t win_d [WIN][WIN];

  always_comb begin
    win_d = win_q;
    if (shift_i) begin
      for (int k = 0; k < WIN; k++) begin
        for (int x = 0; x + 1 < WIN; x++) begin
          win_d[k][x] = win_q[k][x+1];
        end
      end
      win_d[0][WIN-1] = col_i.top;
      win_d[1][WIN-1] = col_i.mid;
      win_d[2][WIN-1] = col_i.bot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN; k++) begin
        for (int x = 0; x < WIN; x++) begin
          win_q[k][x] <= '0;
        end
      end
    end else begin
      win_q <= win_d;
    end
  end

  // Exact Q8.8 sample sum against center * 256; ties set the bit.
  always_comb begin
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] ref_val;
    logic [1:0]       yy;
    logic [1:0]       xx;
    code_o  = '0;
    ref_val = {1'b0, win_q[1][1], 8'd0};
    for (int n = 0; n < NB; n++) begin
      acc = '0;
      for (int t = 0; t < NTAP; t++) begin
        yy  = 2'(1 + int'(TAPS[n][t].dy));
        xx  = 2'(1 + int'(TAPS[n][t].dx));
        acc = acc + ACC_W'(TAPS[n][t].w) * ACC_W'(win_q[yy][xx]);
      end
      code_o[n] = (acc >= ref_val);
    end
  end

endmodule

`default_nettype wire
